### rtl/core/fus_pkg.sv
// Package for the form body encoder: operation codes, character constants
// and the byte classification helpers. No dependencies.
package fus_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_NAME  = 2'd1,
        OP_VALUE = 2'd2,
        OP_DATA  = 2'd3
    } t_op;

    localparam logic [7:0]  CH_PLUS     = 8'h2B;
    localparam logic [7:0]  CH_PCT      = 8'h25;
    localparam logic [7:0]  CH_AMP      = 8'h26;
    localparam logic [7:0]  CH_EQ       = 8'h3D;
    localparam logic [7:0]  CH_SPACE    = 8'h20;
    localparam logic [15:0] LIMIT_RESET = 16'd4096;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'h0, nib};
        end else begin
            return 8'h41 + {4'h0, nib} - 8'd10;
        end
    endfunction

    function automatic logic keeps_literal(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2A || c == 8'h2D ||
               c == 8'h2E || c == 8'h5F;
    endfunction

endpackage

### rtl/core/form_urlencode_stream_top.sv
// The first result beat of an item is registered in the unit buffer and then in the output register.
// One output beat per cycle while i_out_stall is low; markers and literal bytes give one beat,
// escaped bytes three, items without a result none.
// The next item is taken in the cycle the previous unit hands over its last beat.
// Reset (synchronous, active low): length, field and error state cleared, limit 4096.
// Form body encoder top level; depends on fus_pkg.
module form_urlencode_stream_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_overflow,
    output logic [15:0] o_length
);
    import fus_pkg::*;

    logic [15:0] r_limit;
    logic [15:0] r_len;
    logic        r_fs;
    logic        r_failed;

    logic        r_u_vld;
    logic [7:0]  r_u_chr [3];
    logic [1:0]  r_u_cnt;
    logic [1:0]  r_u_pos;
    logic        r_u_ovf;
    logic [15:0] r_u_base;

    logic        r_o_vld;
    logic [7:0]  r_o_byte;
    logic        r_o_last;
    logic        r_o_ovf;
    logic [15:0] r_o_len;

    logic        in_acc;
    logic        u_move;
    logic        u_last;
    logic        unit_en;
    logic [1:0]  unit_n;
    logic [7:0]  unit_chr [3];
    logic        unit_fits;
    logic [16:0] unit_end;
    logic        n_fs;
    t_op         op;

    assign op      = t_op'(i_op);
    assign u_move  = r_u_vld && (!r_o_vld || !i_out_stall);
    assign u_last  = (r_u_pos == r_u_cnt - 2'd1);
    assign o_in_stall = r_u_vld && !(u_move && u_last);
    assign in_acc  = i_in_valid && !o_in_stall;

    always_comb begin
        unit_en     = 1'b0;
        unit_n      = 2'd1;
        unit_chr[0] = CH_AMP;
        unit_chr[1] = hex_digit(i_data_byte[7:4]);
        unit_chr[2] = hex_digit(i_data_byte[3:0]);
        n_fs        = r_fs;
        unique case (op)
            OP_CLEAR: begin
                unit_en = 1'b0;
            end
            OP_NAME: begin
                unit_en = r_fs;
                n_fs    = 1'b1;
            end
            OP_VALUE: begin
                unit_en     = 1'b1;
                unit_chr[0] = CH_EQ;
            end
            OP_DATA: begin
                unit_en = 1'b1;
                if (i_data_byte == CH_SPACE) begin
                    unit_chr[0] = CH_PLUS;
                end else if (keeps_literal(i_data_byte)) begin
                    unit_chr[0] = i_data_byte;
                end else begin
                    unit_chr[0] = CH_PCT;
                    unit_n      = 2'd3;
                end
            end
            default: begin
                unit_en = 1'b0;
            end
        endcase
        unit_end  = {1'b0, r_len} + {15'd0, unit_n};
        unit_fits = (unit_end <= {1'b0, r_limit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_len    <= '0;
            r_fs     <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_acc) begin
                if (op == OP_CLEAR) begin
                    r_len    <= '0;
                    r_fs     <= 1'b0;
                    r_failed <= 1'b0;
                end else if (!r_failed) begin
                    r_fs <= n_fs;
                    if (unit_en) begin
                        if (unit_fits) begin
                            r_len <= unit_end[15:0];
                        end else begin
                            r_failed <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // unit buffer: load on accept of an item with a result, advance one beat per move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
            r_u_pos <= '0;
        end else begin
            if (in_acc && op != OP_CLEAR && !r_failed && unit_en) begin
                r_u_vld <= 1'b1;
                r_u_pos <= '0;
            end else if (u_move) begin
                if (u_last) begin
                    r_u_vld <= 1'b0;
                end
                r_u_pos <= r_u_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_u_base <= r_len;
            if (unit_fits) begin
                r_u_chr[0] <= unit_chr[0];
                r_u_cnt    <= unit_n;
                r_u_ovf    <= 1'b0;
            end else begin
                r_u_chr[0] <= 8'h00;
                r_u_cnt    <= 2'd1;
                r_u_ovf    <= 1'b1;
            end
            r_u_chr[1] <= unit_chr[1];
            r_u_chr[2] <= unit_chr[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (u_move) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (u_move) begin
            r_o_byte <= r_u_chr[r_u_pos];
            r_o_last <= u_last;
            r_o_ovf  <= r_u_ovf;
            r_o_len  <= r_u_ovf ? r_u_base : r_u_base + {14'd0, r_u_pos} + 16'd1;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_byte  = r_o_byte;
    assign o_last      = r_o_last;
    assign o_overflow  = r_o_ovf;
    assign o_length    = r_o_len;

`ifndef SYNTH
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_ovf |-> r_o_last && r_o_byte == 8'h00)
        else $error("overflow beat not a single zero beat");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u_vld |-> r_u_pos < r_u_cnt)
        else $error("unit position past its count");
    a_mid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !r_o_last |=> r_o_vld)
        else $error("escape broken off before last beat");
    a_ovf_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u_vld && r_u_ovf |-> r_u_cnt == 2'd1)
        else $error("overflow unit longer than one beat");
`endif

endmodule

### tb/form_urlencode_stream_top_test.sv
`timescale 1ns / 100ps
// Testbench for form_urlencode_stream_top: directed and random marker/byte beats,
// checked beat by beat against an encoder model kept in this file.
// Depends on fus_pkg and form_urlencode_stream_top.
module form_urlencode_stream_top_test;
    import fus_pkg::*;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        ovf;
        logic [15:0] len;
    } t_enc_beat;

    localparam int HOLD_CYCLES = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid  = 1'b0;
    logic [1:0]  in_op     = 2'd0;
    logic [7:0]  in_byte   = 8'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_ovf;
    logic [15:0] out_len;

    t_enc_beat   encoded_q[$];
    logic [15:0] limit_reg   = LIMIT_RESET;
    logic [15:0] pred_len    = 16'd0;
    logic        field_open  = 1'b0;
    logic        body_failed = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_acted   = 0;
    int unsigned items_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned ovf_beats     = 0;
    int unsigned fail_count    = 0;
    bit          hold_req      = 1'b0;
    bit          hold_ack      = 1'b0;
    int unsigned hold_cnt      = 0;

    form_urlencode_stream_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_op        (in_op),
        .i_data_byte (in_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_last      (out_last),
        .o_overflow  (out_ovf),
        .o_length    (out_len)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib > 4'd9) ? 8'd55 + {4'h0, nib} : 8'd48 + {4'h0, nib};
    endfunction

    function automatic bit is_unreserved(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "*" || b == "-" || b == "." || b == "_";
    endfunction

    function automatic void predict_encoding(input t_op op, input logic [7:0] b);
        logic [7:0] unit_ch [3];
        int         n;
        n = 0;
        if (op == OP_CLEAR) begin
            pred_len    = 16'd0;
            field_open  = 1'b0;
            body_failed = 1'b0;
            items_acted++;
            return;
        end
        if (body_failed) begin
            return;
        end
        items_acted++;
        case (op)
            OP_NAME: begin
                if (!field_open) begin
                    field_open = 1'b1;
                    return;
                end
                unit_ch[0] = CH_AMP;
                n = 1;
            end
            OP_VALUE: begin
                unit_ch[0] = CH_EQ;
                n = 1;
            end
            default: begin
                if (b == CH_SPACE) begin
                    unit_ch[0] = CH_PLUS;
                    n = 1;
                end else if (is_unreserved(b)) begin
                    unit_ch[0] = b;
                    n = 1;
                end else begin
                    unit_ch[0] = CH_PCT;
                    unit_ch[1] = hex_char(b[7:4]);
                    unit_ch[2] = hex_char(b[3:0]);
                    n = 3;
                end
            end
        endcase
        if (int'(pred_len) + n > int'(limit_reg)) begin
            body_failed = 1'b1;
            encoded_q.push_back('{ch: 8'd0, last: 1'b1, ovf: 1'b1, len: pred_len});
        end else begin
            for (int k = 0; k < n; k++) begin
                pred_len = pred_len + 16'd1;
                encoded_q.push_back('{ch: unit_ch[k], last: (k == n - 1), ovf: 1'b0,
                                      len: pred_len});
            end
        end
    endfunction

    // receiver: random stall, or a long hold-off on request
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_enc_beat exp_beat;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            beats_checked++;
            if (out_ovf === 1'b1) begin
                ovf_beats++;
            end
            if (encoded_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got byte %h last %b ovf %b len %0d",
                         $time, out_byte, out_last, out_ovf, out_len);
                fail_count++;
            end else begin
                exp_beat = encoded_q.pop_front();
                if (out_byte !== exp_beat.ch) begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, exp_beat.ch, out_byte);
                    fail_count++;
                end
                if (out_last !== exp_beat.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, exp_beat.last, out_last);
                    fail_count++;
                end
                if (out_ovf !== exp_beat.ovf) begin
                    $display("%0t: overflow mismatch: expected %b, actual %b",
                             $time, exp_beat.ovf, out_ovf);
                    fail_count++;
                end
                if (out_len !== exp_beat.len) begin
                    $display("%0t: length mismatch: expected %0d, actual %0d",
                             $time, exp_beat.len, out_len);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(input t_op op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        items_sent++;
        predict_encoding(op, b);
    endtask

    // drop valid, wait for every expected beat, then let in-flight items settle
    task automatic drain();
        in_valid <= 1'b0;
        while (encoded_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg = value;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0:       return 8'h61 + 8'($urandom_range(25));
            1:       return 8'h41 + 8'($urandom_range(25));
            2:       return 8'h30 + 8'($urandom_range(9));
            3: begin
                case ($urandom_range(3))
                    0:       return "*";
                    1:       return "-";
                    2:       return ".";
                    default: return "_";
                endcase
            end
            4:       return CH_SPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_encoding_classes();
        send_item(OP_NAME, 8'h00);
        send_item(OP_DATA, "a");
        send_item(OP_DATA, "Z");
        send_item(OP_DATA, "0");
        send_item(OP_DATA, "9");
        send_item(OP_DATA, "*");
        send_item(OP_DATA, "-");
        send_item(OP_DATA, ".");
        send_item(OP_DATA, "_");
        send_item(OP_DATA, CH_SPACE);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, "~");
        send_item(OP_VALUE, 8'hFF);
        send_item(OP_NAME, 8'h55);
        send_item(OP_CLEAR, 8'hAA);
        send_item(OP_DATA, "x");
        send_item(OP_VALUE, 8'h00);
    endtask

    task automatic test_limit_edges();
        write_limit(16'd5);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_NAME, 8'h00);
        send_item(OP_DATA, "a");
        send_item(OP_VALUE, 8'h00);
        send_item(OP_DATA, 8'h80);
        send_item(OP_DATA, "b");
        send_item(OP_DATA, "c");
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_DATA, 8'h7F);
        write_limit(16'd0);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_NAME, 8'h00);
        send_item(OP_NAME, 8'h00);
        send_item(OP_CLEAR, 8'h00);
        write_limit(LIMIT_RESET);
        send_item(OP_DATA, 8'h3C);
        send_item(OP_DATA, "q");
        write_limit(16'd2);
        send_item(OP_DATA, "r");
        send_item(OP_CLEAR, 8'h00);
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned clear_pct);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_item(t_op'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < clear_pct) begin
                    send_item(OP_CLEAR, 8'($urandom_range(255)));
                end
                send_item(OP_NAME, 8'($urandom_range(255)));
                repeat ($urandom_range(1, 5)) send_item(OP_DATA, pick_byte());
                send_item(OP_VALUE, 8'($urandom_range(255)));
                repeat ($urandom_range(0, 6)) send_item(OP_DATA, pick_byte());
            end
        end
    endtask

    task automatic test_backpressure_fill();
        write_limit(LIMIT_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(OP_CLEAR, 8'h00);
        hold_req = ~hold_req;
        repeat (40) begin
            if ($urandom_range(3) == 0) begin
                send_item(OP_VALUE, 8'h00);
            end else begin
                send_item(OP_DATA, 8'($urandom_range(255)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 14;
        recv_idle_pct = 50;
        test_encoding_classes();
        test_limit_edges();

        write_limit(16'hFFFF);
        send_item(OP_CLEAR, 8'h00);
        run_random_phase(70, 10);

        write_limit(16'd40);
        send_idle_pct = 50;
        recv_idle_pct = 14;
        send_item(OP_CLEAR, 8'h00);
        run_random_phase(70, 30);

        test_backpressure_fill();

        write_limit(16'($urandom_range(16, 300)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(70, 15);

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d items (%0d acted on), checked %0d result beats, %0d overflows.",
                 items_sent, items_acted, beats_checked, ovf_beats);
        $display("Limits 0 to 65535, idle mixes both ways, one long output hold-off.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d beats still expected", encoded_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
